// ----- hdl/nfwd_pkg.sv -----
// ----------------------------------------------------------------------------
// nfwd_pkg: shared types and constants of the near/far word decompressor
// Payload structs, tag codes, history sizing and sequencer encodings.
// ----------------------------------------------------------------------------
package nfwd_pkg;

  // history sizing
  localparam int HISTORY_WORDS = 8192;
  localparam int HIST_AW       = $clog2(HISTORY_WORDS);
  localparam int WP_W          = HIST_AW + 1;   // holds 0..HISTORY_WORDS

  // configuration port
  localparam int CFG_LEN_W = 14;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam logic REG_OUTPUT_LENGTH = 1'b0;    // paddr[2] of output_length_words

  // stream tags
  localparam logic [7:0] TAG_NEAR = 8'hA7;
  localparam logic [7:0] TAG_FAR  = 8'hA8;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       stream_start;
  } nfwd_in_t;

  typedef struct packed {
    logic [15:0] out_word_a;
    logic [15:0] out_word_b;
    logic [15:0] out_word_c;
    logic [15:0] out_word_d;
    logic [2:0]  valid_count;
    logic        run_last;
    logic        stream_done;
    logic        bad_reference;
  } nfwd_out_t;

  // byte parser phase
  typedef enum logic [5:0] {
    PH_LOW       = 6'b000001,
    PH_HIGH      = 6'b000010,
    PH_ESC       = 6'b000100,
    PH_NEAR_DIST = 6'b001000,
    PH_FAR_LO    = 6'b010000,
    PH_FAR_HI    = 6'b100000
  } nfwd_phase_t;

  // copy sequencer
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_WR   = 4'b0100,
    ST_OUT  = 4'b1000
  } nfwd_state_t;

endpackage

// ----- hdl/near_far_word_decompressor.sv -----
// ----------------------------------------------------------------------------
// near_far_word_decompressor: byte-serial near/far tag word decompressor
// Rebuilds 16-bit words from a tagged compressed byte stream, up to four
// decoded words per output transfer.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_stall/in_data): one compressed byte per
//   transfer. Set stream_start on the first byte of a stream; it clears the
//   pointers, parser and error flag and latches output_length_words.
//   Output channel (out_valid/out_stall/out_data): every input byte gives at
//   least one transfer; run_last marks the last one of that byte.
//   APB port: output_length_words at byte address 0, written while idle.
// Timing
//   The block works on one byte at a time; in_stall is high until the last
//   output transfer of the byte has gone. A byte that yields no word or one
//   word shows its result the cycle after it is taken. A copy of n words
//   runs through the history RAM one word at a time (read, then write back),
//   with an output transfer after every four copied words and after the last.
//   Output stall simply holds the sequencer; the result is kept steady.
// Reset
//   rst_n (synchronous) clears all control state. The history RAM is not
//   cleared: a stream reads only entries it has itself written.
// ----------------------------------------------------------------------------
module near_far_word_decompressor (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  nfwd_pkg::nfwd_in_t            in_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output nfwd_pkg::nfwd_out_t           out_data,
  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nfwd_pkg::PADDR_W-1:0]  paddr,
  input  logic [nfwd_pkg::PDATA_W-1:0]  pwdata,
  output logic [nfwd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import nfwd_pkg::*;

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  nfwd_state_t          st_r,     st_nxt;
  nfwd_phase_t          ph_r,     ph_nxt;
  logic [WP_W-1:0]      wp_r,     wp_nxt;     // write position
  logic [WP_W-1:0]      rem_r,    rem_nxt;    // words remaining after this byte
  logic [15:0]          held_r,   held_nxt;   // assembled tag or literal word
  logic [7:0]           offlo_r,  offlo_nxt;  // far offset, low byte
  logic                 fault_r,  fault_nxt;
  logic [HIST_AW-1:0]   src_r,    src_nxt;    // copy read pointer
  logic [7:0]           left_r,   left_nxt;   // copy words still to move
  logic [2:0]           cnt_r,    cnt_nxt;    // words held for this transfer
  logic                 last_r,   last_nxt;   // transfer closes the byte
  logic [CFG_LEN_W-1:0] len_r;

  logic [15:0]          wbuf_r [4];           // output gather buffer
  logic [15:0]          hist_mem [HISTORY_WORDS];
  logic [15:0]          rd_data_r;

  // --------------------------------------------------------------------------
  // APB: single length register, always ready
  // --------------------------------------------------------------------------
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == REG_OUTPUT_LENGTH);
  assign prdata = (paddr[2] == REG_OUTPUT_LENGTH) ?
                  PDATA_W'(len_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cfg_wr) begin
      len_r <= pwdata[CFG_LEN_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // handshakes
  // --------------------------------------------------------------------------
  logic in_acc;
  logic out_acc;

  assign in_stall  = (st_r != ST_IDLE);
  assign out_valid = (st_r == ST_OUT);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  // --------------------------------------------------------------------------
  // stream start folded in ahead of the parser
  // --------------------------------------------------------------------------
  nfwd_phase_t     ph_e;
  logic [WP_W-1:0] wp_e;
  logic [WP_W-1:0] rem_e;
  logic [WP_W-1:0] len_sat;
  logic [15:0]     held_e;
  logic [7:0]      offlo_e;
  logic            fault_e;

  assign len_sat = (32'(len_r) > HISTORY_WORDS) ? WP_W'(HISTORY_WORDS) : WP_W'(len_r);

  always_comb begin
    if (in_data.stream_start) begin
      ph_e    = PH_LOW;
      wp_e    = '0;
      rem_e   = len_sat;
      held_e  = '0;
      offlo_e = '0;
      fault_e = 1'b0;
    end else begin
      ph_e    = ph_r;
      wp_e    = wp_r;
      rem_e   = rem_r;
      held_e  = held_r;
      offlo_e = offlo_r;
      fault_e = fault_r;
    end
  end

  // byte decode helpers
  logic [7:0]       b;
  logic [7:0]       count;
  logic [7:0]       ncopy;       // count clipped at the remaining length
  logic [15:0]      far_off;
  logic             near_bad;
  logic             far_bad;
  logic [WP_W-1:0]  near_src;

  assign b        = in_data.stream_byte;
  assign count    = held_e[7:0];
  assign ncopy    = (WP_W'(count) <= rem_e) ? count : rem_e[7:0];
  assign far_off  = {b, offlo_e};
  assign near_bad = (b == 8'd0) || (WP_W'(b) > wp_e);
  assign far_bad  = (far_off >= 16'(wp_e));
  assign near_src = wp_e - WP_W'(b);

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  logic               mem_we;
  logic [HIST_AW-1:0] mem_wa;
  logic [15:0]        mem_wd;
  logic               wbuf_we;
  logic [1:0]         wbuf_wa;

  always_comb begin
    st_nxt    = st_r;
    ph_nxt    = ph_r;
    wp_nxt    = wp_r;
    rem_nxt   = rem_r;
    held_nxt  = held_r;
    offlo_nxt = offlo_r;
    fault_nxt = fault_r;
    src_nxt   = src_r;
    left_nxt  = left_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    mem_we    = 1'b0;
    mem_wa    = wp_r[HIST_AW-1:0];
    mem_wd    = rd_data_r;
    wbuf_we   = 1'b0;
    wbuf_wa   = cnt_r[1:0];

    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          ph_nxt    = ph_e;
          wp_nxt    = wp_e;
          rem_nxt   = rem_e;
          held_nxt  = held_e;
          offlo_nxt = offlo_e;
          fault_nxt = fault_e;
          cnt_nxt   = '0;
          last_nxt  = 1'b1;
          st_nxt    = ST_OUT;
          mem_wa    = wp_e[HIST_AW-1:0];
          wbuf_wa   = 2'd0;
          if (rem_e != '0) begin
            case (ph_e)
              PH_LOW: begin
                held_nxt = {8'd0, b};
                ph_nxt   = PH_HIGH;
              end
              PH_HIGH: begin
                held_nxt = {b, held_e[7:0]};
                if (b == TAG_NEAR || b == TAG_FAR) begin
                  if (count == 8'd0) begin
                    ph_nxt = PH_ESC;
                  end else if (b == TAG_NEAR) begin
                    ph_nxt = PH_NEAR_DIST;
                  end else begin
                    ph_nxt = PH_FAR_LO;
                  end
                end else begin
                  // literal
                  mem_we  = 1'b1;
                  mem_wd  = {b, held_e[7:0]};
                  wbuf_we = 1'b1;
                  wp_nxt  = wp_e + 1'b1;
                  rem_nxt = rem_e - 1'b1;
                  cnt_nxt = 3'd1;
                  ph_nxt  = PH_LOW;
                end
              end
              PH_ESC: begin
                mem_we  = 1'b1;
                mem_wd  = {held_e[15:8], b};
                wbuf_we = 1'b1;
                wp_nxt  = wp_e + 1'b1;
                rem_nxt = rem_e - 1'b1;
                cnt_nxt = 3'd1;
                ph_nxt  = PH_LOW;
              end
              PH_NEAR_DIST: begin
                ph_nxt = PH_LOW;
                if (near_bad) begin
                  fault_nxt = 1'b1;
                  rem_nxt   = '0;
                end else begin
                  src_nxt  = near_src[HIST_AW-1:0];
                  left_nxt = ncopy;
                  rem_nxt  = rem_e - WP_W'(ncopy);
                  last_nxt = 1'b0;
                  st_nxt   = ST_RD;
                end
              end
              PH_FAR_LO: begin
                offlo_nxt = b;
                ph_nxt    = PH_FAR_HI;
              end
              PH_FAR_HI: begin
                ph_nxt = PH_LOW;
                if (far_bad) begin
                  fault_nxt = 1'b1;
                  rem_nxt   = '0;
                end else begin
                  src_nxt  = far_off[HIST_AW-1:0];
                  left_nxt = ncopy;
                  rem_nxt  = rem_e - WP_W'(ncopy);
                  last_nxt = 1'b0;
                  st_nxt   = ST_RD;
                end
              end
              default: begin
                ph_nxt = PH_LOW;
              end
            endcase
          end
        end
      end
      ST_RD: begin
        st_nxt = ST_WR;
      end
      ST_WR: begin
        // copied word goes back into history and into the gather buffer
        mem_we   = 1'b1;
        wbuf_we  = 1'b1;
        wp_nxt   = wp_r + 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        src_nxt  = src_r + 1'b1;
        left_nxt = left_r - 1'b1;
        if (left_r == 8'd1) begin
          last_nxt = 1'b1;
          st_nxt   = ST_OUT;
        end else if (cnt_r == 3'd3) begin
          st_nxt = ST_OUT;
        end else begin
          st_nxt = ST_RD;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          if (last_r) begin
            st_nxt = ST_IDLE;
          end else begin
            cnt_nxt = '0;
            st_nxt  = ST_RD;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      ph_r    <= PH_LOW;
      wp_r    <= '0;
      rem_r   <= '0;
      held_r  <= '0;
      offlo_r <= '0;
      fault_r <= 1'b0;
      src_r   <= '0;
      left_r  <= '0;
      cnt_r   <= '0;
      last_r  <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      ph_r    <= ph_nxt;
      wp_r    <= wp_nxt;
      rem_r   <= rem_nxt;
      held_r  <= held_nxt;
      offlo_r <= offlo_nxt;
      fault_r <= fault_nxt;
      src_r   <= src_nxt;
      left_r  <= left_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // history RAM: one write, one registered read
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_RD) begin
      rd_data_r <= hist_mem[src_r];
    end
  end

  // gather buffer (payload, no reset)
  always_ff @(posedge clk) begin
    if (wbuf_we) begin
      wbuf_r[wbuf_wa] <= mem_wd;
    end
  end

  // --------------------------------------------------------------------------
  // result; unused word slots read as zero
  // --------------------------------------------------------------------------
  always_comb begin
    out_data.out_word_a    = (cnt_r > 3'd0) ? wbuf_r[0] : 16'd0;
    out_data.out_word_b    = (cnt_r > 3'd1) ? wbuf_r[1] : 16'd0;
    out_data.out_word_c    = (cnt_r > 3'd2) ? wbuf_r[2] : 16'd0;
    out_data.out_word_d    = (cnt_r > 3'd3) ? wbuf_r[3] : 16'd0;
    out_data.valid_count   = cnt_r;
    out_data.run_last      = last_r;
    out_data.stream_done   = (rem_r == '0);
    out_data.bad_reference = fault_r;
  end

`ifndef SYNTHESIS
  // at most four words per transfer
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.valid_count <= 3'd4))
    else $error("valid_count above four");

  // only the closing transfer of a byte may be short
  a_full_unless_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.run_last) |-> (out_data.valid_count == 3'd4))
    else $error("short transfer before end of copy");

  // a faulted stream emits nothing
  a_fault_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.bad_reference) |-> (out_data.valid_count == 3'd0))
    else $error("words emitted after bad reference");

  // pointer plus remaining length never runs past the history
  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(wp_r) + 32'(rem_r)) <= HISTORY_WORDS)
    else $error("write position overruns history");
`endif

endmodule
